[rtl/note_sequencer_tone_generator_assert.svh]
// Assertion macros for the melody player.
// Expects clk and arst_n in the scope of the use.
`ifndef NOTE_SEQUENCER_TONE_GENERATOR_ASSERT_SVH
`define NOTE_SEQUENCER_TONE_GENERATOR_ASSERT_SVH

// same-cycle implication
`define NSTG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NSTG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/nstg_pkg.sv]
// Shared types and constants of the melody player.
// No dependencies.
`default_nettype none
package nstg_pkg;

	localparam int MAX_NOTES_DEF = 256;

	localparam int ACTION_W = 2;
	localparam int NOTE_W   = 8;
	localparam int FREQ_W   = 16;
	localparam int DUR_W    = 16;
	localparam int TICK_W   = 22;
	localparam int LEN_W    = 9;
	localparam int VOL_W    = 8;
	localparam int LEN_CAP  = 256;
	localparam int ENTRY_W  = FREQ_W + DUR_W;

	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 4;

	localparam int DIV_W     = 15;
	localparam int DIV_CNT_W = 4;
	localparam logic [DIV_W-1:0]     DIVIDEND = 15'd31250;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);
	localparam logic [6:0]           TICK_MUL = 7'd125;

	localparam logic [1:0] REG_VOLUME = 2'd0;
	localparam logic [1:0] REG_LOOP   = 2'd1;
	localparam logic [1:0] REG_LENGTH = 2'd2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK  = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_START = 2'd2,
		ACT_STOP  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [VOL_W-1:0] volume;
		logic             loop_enable;
		logic [LEN_W-1:0] song_length;
	} cfg_t;

	typedef struct packed {
		logic exec;
		logic rd_en;
		logic load;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic need_select;
		logic rest;
		logic div_last;
	} sts_t;

	typedef struct packed {
		logic [VOL_W-1:0]  level;
		logic              gate;
		logic              playing;
		logic [NOTE_W-1:0] current_note;
		logic              song_ended;
	} res_t;

endpackage
`default_nettype wire

[rtl/nstg_in_if.sv]
// Input channel of the melody player: valid/ready plus one action item.
// No dependencies.
`default_nettype none
interface nstg_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  note_index;
	logic [15:0] note_frequency;
	logic [15:0] note_duration_ms;

	modport source (output valid, action, note_index, note_frequency, note_duration_ms,
		input ready);
	modport sink (input valid, action, note_index, note_frequency, note_duration_ms,
		output ready);
endinterface
`default_nettype wire

[rtl/nstg_out_if.sv]
// Output channel of the melody player: valid/ready plus one result item.
// No dependencies.
`default_nettype none
interface nstg_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] level;
	logic       gate;
	logic       playing;
	logic [7:0] current_note;
	logic       song_ended;

	modport source (output valid, level, gate, playing, current_note, song_ended,
		input ready);
	modport sink (input valid, level, gate, playing, current_note, song_ended,
		output ready);
endinterface
`default_nettype wire

[rtl/note_sequencer_tone_generator.sv]
// Square-wave melody player, top level: APB registers, controller, datapath.
// An action ends in a result load; a tone note selection first does a table read,
// duration load and 15-step restoring divide, a rest only the read and load.
// New actions wait for the result load, which waits for a free output slot.
// Reset (arst_n low, asynchronous) clears counters, stops play, sets gate;
// note tables are not cleared. Depends on nstg_pkg, interfaces, submodules.
`default_nettype none
`include "note_sequencer_tone_generator_assert.svh"
module note_sequencer_tone_generator #(
	parameter int MAX_NOTES = nstg_pkg::MAX_NOTES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [nstg_pkg::PADDR_W-1:0] paddr,
	input  wire logic [nstg_pkg::DATA_W-1:0]  pwdata,
	output      logic [nstg_pkg::DATA_W-1:0]  prdata,
	output      logic                         pready,
	nstg_in_if.sink                           in_ch,
	nstg_out_if.source                        out_ch
);
	import nstg_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	res_t res;

	nstg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nstg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	nstg_dp #(
		.MAX_NOTES (MAX_NOTES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg),
		.cmd              (cmd),
		.sts              (sts),
		.action           (in_ch.action),
		.note_index       (in_ch.note_index),
		.note_frequency   (in_ch.note_frequency),
		.note_duration_ms (in_ch.note_duration_ms),
		.res              (res)
	);

	assign out_ch.level        = res.level;
	assign out_ch.gate         = res.gate;
	assign out_ch.playing      = res.playing;
	assign out_ch.current_note = res.current_note;
	assign out_ch.song_ended   = res.song_ended;

	`NSTG_ASSERT_NOW(a_cmd_onehot, 1'b1, $onehot0({cmd.exec, cmd.rd_en, cmd.load, cmd.div_step, cmd.out_load}), "more than one command active")
	`NSTG_ASSERT_NEXT(a_read_then_load, cmd.rd_en, cmd.load, "table read not followed by load")
	`NSTG_ASSERT_NEXT(a_load_then_div, cmd.load && !sts.rest, cmd.div_step, "tone note load not followed by divide")
	`NSTG_ASSERT_NEXT(a_result_valid, cmd.out_load, out_ch.valid, "result load did not raise valid")
endmodule
`default_nettype wire

[rtl/nstg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nstg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

[rtl/nstg_regs.sv]
// APB-style configuration registers: volume, loop enable, song length.
// Depends on nstg_pkg.
`default_nettype none
module nstg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [nstg_pkg::PADDR_W-1:0]  paddr,
	input  wire logic [nstg_pkg::DATA_W-1:0]   pwdata,
	output      logic [nstg_pkg::DATA_W-1:0]   prdata,
	output      logic                          pready,
	output      nstg_pkg::cfg_t                cfg
);
	import nstg_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume      <= '0;
			cfg_q.loop_enable <= 1'b0;
			cfg_q.song_length <= LEN_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_VOLUME: cfg_q.volume      <= pwdata[VOL_W-1:0];
				REG_LOOP:   cfg_q.loop_enable <= pwdata[0];
				REG_LENGTH: cfg_q.song_length <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_VOLUME: prdata = DATA_W'(cfg_q.volume);
			REG_LOOP:   prdata = DATA_W'(cfg_q.loop_enable);
			REG_LENGTH: prdata = DATA_W'(cfg_q.song_length);
			default:    prdata = '0;
		endcase
	end
endmodule
`default_nettype wire

[rtl/nstg_ctrl.sv]
// Controller state machine: accepts an action, sequences table read,
// divide and result transfer. Depends on nstg_pkg.
`default_nettype none
module nstg_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	output      logic           out_valid,
	input  wire logic           out_ready,
	input  wire nstg_pkg::sts_t sts,
	output      nstg_pkg::cmd_t cmd
);
	import nstg_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.exec = 1'b1;
					state_d  = sts.need_select ? ST_READ : ST_FINISH;
				end
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = sts.rest ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output slot is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[rtl/nstg_dp.sv]
// Datapath: note tables, tone and note counters, quotient divider,
// result register. Depends on nstg_pkg and nstg_ram.
`default_nettype none
module nstg_dp #(
	parameter int MAX_NOTES = nstg_pkg::MAX_NOTES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire nstg_pkg::cfg_t                cfg,
	input  wire nstg_pkg::cmd_t                cmd,
	output      nstg_pkg::sts_t                sts,
	input  wire logic [nstg_pkg::ACTION_W-1:0] action,
	input  wire logic [nstg_pkg::NOTE_W-1:0]   note_index,
	input  wire logic [nstg_pkg::FREQ_W-1:0]   note_frequency,
	input  wire logic [nstg_pkg::DUR_W-1:0]    note_duration_ms,
	output      nstg_pkg::res_t                res
);
	import nstg_pkg::*;

	localparam int ADDR_W    = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int LEN_LIM_I = (MAX_NOTES < LEN_CAP) ? MAX_NOTES : LEN_CAP;
	localparam logic [LEN_W-1:0] LEN_LIM = LEN_W'(LEN_LIM_I);

	action_t            act;
	logic [NOTE_W-1:0]  note_pos_q;
	logic [TICK_W-1:0]  elapsed_q;
	logic [TICK_W-1:0]  tick_limit_q;
	logic [FREQ_W-1:0]  tone_div_q;
	logic [FREQ_W-1:0]  tone_cnt_q;
	logic               gate_q;
	logic               running_q;
	logic               rest_q;
	logic               ended_q;

	logic [DIV_W-1:0]     dvd_q;
	logic [FREQ_W-1:0]    rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [FREQ_W-1:0]    divisor_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	res_t res_q;

	logic               we;
	logic [ENTRY_W-1:0] rd_data;
	logic [FREQ_W-1:0]  rd_freq;
	logic [DUR_W-1:0]   rd_dur;
	logic [TICK_W:0]    limit_prod;

	logic [LEN_W-1:0]   eff_len;
	logic [LEN_W-1:0]   next_pos;
	logic [TICK_W-1:0]  el_inc;
	logic               tick_over;
	logic               at_end;
	logic               tick_sel;
	logic               song_stop;
	logic               need_sel;
	logic [FREQ_W-1:0]  tone_cnt_n;

	logic [FREQ_W:0]    trial;
	logic               ge;
	logic [FREQ_W-1:0]  rem_n;
	logic [DIV_W-1:0]   quo_n;
	logic               g;

	assign act = action_t'(action);

	nstg_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_NOTES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (ADDR_W'(note_index)),
		.wdata ({note_frequency, note_duration_ms}),
		.re    (cmd.rd_en),
		.raddr (ADDR_W'(note_pos_q)),
		.rdata (rd_data)
	);

	assign we = cmd.exec && (act == ACT_LOAD) && (32'(note_index) < MAX_NOTES);

	assign rd_freq    = rd_data[ENTRY_W-1:DUR_W];
	assign rd_dur     = rd_data[DUR_W-1:0];
	assign limit_prod = (TICK_W+1)'(rd_dur) * (TICK_W+1)'(TICK_MUL);

	always_comb begin
		eff_len = (cfg.song_length > LEN_LIM) ? LEN_LIM : cfg.song_length;
		if (eff_len == '0) begin
			eff_len = LEN_W'(1);
		end
	end

	assign next_pos  = LEN_W'(note_pos_q) + LEN_W'(1);
	assign el_inc    = elapsed_q + TICK_W'(1);
	assign tick_over = el_inc > tick_limit_q;
	assign at_end    = next_pos >= eff_len;
	assign tick_sel  = running_q && tick_over && (!at_end || cfg.loop_enable);
	assign song_stop = running_q && tick_over && at_end && !cfg.loop_enable;

	assign tone_cnt_n = rest_q ? tone_cnt_q
		: (tone_cnt_q == tone_div_q) ? '0 : tone_cnt_q + FREQ_W'(1);

	always_comb begin
		case (act)
			ACT_START: need_sel = 1'b1;
			ACT_TICK:  need_sel = tick_sel;
			default:   need_sel = 1'b0;
		endcase
	end

	assign sts.need_select = need_sel;
	assign sts.rest        = (rd_freq == '0);
	assign sts.div_last    = (div_cnt_q == DIV_LAST);

	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign rem_n = ge ? FREQ_W'(trial - {1'b0, divisor_q}) : trial[FREQ_W-1:0];
	assign quo_n = {quo_q[DIV_W-2:0], ge};

	assign g = !rest_q && gate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_pos_q   <= '0;
			elapsed_q    <= '0;
			tick_limit_q <= '0;
			tone_div_q   <= '0;
			tone_cnt_q   <= '0;
			gate_q       <= 1'b1;
			running_q    <= 1'b0;
			rest_q       <= 1'b0;
			ended_q      <= 1'b0;
			div_cnt_q    <= '0;
		end else begin
			if (cmd.exec) begin
				ended_q <= (act == ACT_TICK) && song_stop;
				case (act)
					ACT_START: begin
						note_pos_q <= '0;
						elapsed_q  <= '0;
						tone_cnt_q <= '0;
						running_q  <= 1'b1;
					end
					ACT_STOP: running_q <= 1'b0;
					ACT_TICK: begin
						if (running_q) begin
							if (!rest_q && (tone_cnt_q == tone_div_q)) begin
								gate_q <= !gate_q;
							end
							tone_cnt_q <= tick_sel ? '0 : tone_cnt_n;
							if (tick_over) begin
								elapsed_q <= '0;
								if (at_end) begin
									if (cfg.loop_enable) begin
										note_pos_q <= '0;
									end else begin
										running_q <= 1'b0;
									end
								end else begin
									note_pos_q <= next_pos[NOTE_W-1:0];
								end
							end else begin
								elapsed_q <= el_inc;
							end
						end
					end
					default: ;
				endcase
			end
			if (cmd.load) begin
				tick_limit_q <= limit_prod[TICK_W:1];
				div_cnt_q    <= '0;
				if (sts.rest) begin
					rest_q     <= 1'b1;
					tone_div_q <= '0;
				end else begin
					rest_q <= 1'b0;
				end
			end
			if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
				if (sts.div_last) begin
					tone_div_q <= FREQ_W'(quo_n) - FREQ_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			divisor_q <= rd_freq;
			rem_q     <= '0;
			quo_q     <= '0;
			dvd_q     <= DIVIDEND;
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			res_q.level        <= (g && running_q) ? cfg.volume : '0;
			res_q.gate         <= g;
			res_q.playing      <= running_q;
			res_q.current_note <= note_pos_q;
			res_q.song_ended   <= ended_q;
		end
	end

	assign res = res_q;
endmodule
`default_nettype wire
